// File: sv/mtkr_pkg.sv
// ----------------------------------------------------------------------------
// mtkr_pkg
// Shared constants, types and controller/datapath interface structs for the
// minimum threshold search over runs of K adjacent values.
// ----------------------------------------------------------------------------
package mtkr_pkg;

	localparam int MAX_ITEMS  = 1024;
	localparam int VALUE_BITS = 30;
	localparam int CFG_BITS   = 11;
	localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
	localparam int ADDR_BITS  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int PROD_BITS  = 2 * CFG_BITS;
	localparam int IDX_BITS   = 1;

	localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_ITEMS);

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_BOUQUET_COUNT = 1'd0;
	localparam logic [IDX_BITS-1:0] REG_BOUQUET_SIZE  = 1'd1;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [CFG_BITS-1:0]   cfg_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;

	typedef struct packed {
		logic load;          // store one request
		logic capture_prod;  // register M*K
		logic start_scan;    // begin a pass over the store
		logic thr_max;       // pass threshold is the running max, else the midpoint
		logic init_search;   // low/high from min/max
		logic update_search; // narrow the interval from the last pass
		logic finish;        // load result registers and clear the load state
		logic result_ok;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic count_ok;
		logic feasible;
		logic low_lt_high;
	} dp_status_t;

endpackage

// File: sv/min_threshold_for_k_runs_search.sv
// ----------------------------------------------------------------------------
// min_threshold_for_k_runs_search
// Loads an array of day values, then binary-searches the smallest threshold
// that yields M disjoint runs of K adjacent values at or below it.
// ----------------------------------------------------------------------------
// loading: one request per cycle into a single-port value store
// search: after the last request, a check state, one pass over the store at
//   the max, then one pass per binary search step (up to VALUE_BITS+1 passes in
//   all); each binary search step opens in a step state before its pass
// result: a finish state, registered, may wait for out_ready while the next array loads
// reset: asynchronous, clears load state and sets both registers to 1
module min_threshold_for_k_runs_search import mtkr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  value_t              day_value,
	input  logic                is_last,
	output logic                out_valid,
	input  logic                out_ready,
	output value_t              min_day,
	output logic                possible,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  cfg_t                cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	mtkr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mtkr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.day_value (day_value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.min_day   (min_day),
		.possible  (possible)
	);

`ifndef NO_ASSERTIONS
	// a failed search always reports zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !possible) |-> (min_day == '0))
		else $error("not-possible result with nonzero min_day");

	// no request is taken while a pass over the store is in flight
	a_no_load_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> status.scan_done)
		else $error("ready while scanning");

	// the last request closes loading
	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && is_last) |=> !in_ready)
		else $error("still loading after last request");

	// only one datapath command that moves the interval at a time
	a_one_interval_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.init_search && cmd.update_search))
		else $error("conflicting search interval commands");
`endif

endmodule

// File: sv/mtkr_dp.sv
// ----------------------------------------------------------------------------
// mtkr_dp
// Datapath: value store, running min/max, greedy run counter and the binary
// search interval registers.
// ----------------------------------------------------------------------------
module mtkr_dp import mtkr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	output dp_status_t         status,
	input  value_t             day_value,
	input  logic               cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  cfg_t               cfg_data,
	output value_t             min_day,
	output logic               possible
);

	value_t mem [MAX_ITEMS];

	cfg_t   bouquet_count_q, bouquet_size_q;
	cfg_t   m_eff, k_eff;
	cnt_t   count_q;
	value_t min_q, max_q, low_q, high_q, thr_q, mid;
	logic [PROD_BITS-1:0] prod_q;

	cnt_t   rd_addr_q;
	logic   issuing_q;
	logic   vld_s1;
	value_t data_s1;
	cfg_t   len_q;
	cnt_t   runs_q;
	logic [CFG_BITS:0] len_next;

	value_t min_day_q;
	logic   possible_q;

	// a zero register reads as one
	assign m_eff = (bouquet_count_q == '0) ? CFG_BITS'(1) : bouquet_count_q;
	assign k_eff = (bouquet_size_q == '0) ? CFG_BITS'(1) : bouquet_size_q;

	assign mid = low_q + ((high_q - low_q) >> 1);

	assign len_next = (data_s1 <= thr_q) ? ({1'b0, len_q} + (CFG_BITS+1)'(1)) : '0;

	assign status.scan_done   = !issuing_q && !vld_s1;
	assign status.count_ok    = PROD_BITS'(count_q) >= prod_q;
	assign status.feasible    = runs_q >= CNT_BITS'(m_eff);
	assign status.low_lt_high = low_q < high_q;

	assign min_day  = min_day_q;
	assign possible = possible_q;

	always_ff @(posedge clk) begin
		if (cmd.load && count_q < MAX_COUNT) begin
			mem[count_q[ADDR_BITS-1:0]] <= day_value;
		end
		if (issuing_q) begin
			data_s1 <= mem[rd_addr_q[ADDR_BITS-1:0]];
		end
		if (cmd.capture_prod) begin
			prod_q <= m_eff * k_eff;
		end
		if (cmd.finish) begin
			min_day_q  <= cmd.result_ok ? high_q : '0;
			possible_q <= cmd.result_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bouquet_count_q <= CFG_BITS'(1);
			bouquet_size_q  <= CFG_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOUQUET_COUNT: bouquet_count_q <= cfg_data;
				REG_BOUQUET_SIZE:  bouquet_size_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// load state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end else if (cmd.finish) begin
			count_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end else if (cmd.load && count_q < MAX_COUNT) begin
			count_q <= count_q + CNT_BITS'(1);
			if (day_value < min_q) begin
				min_q <= day_value;
			end
			if (day_value > max_q) begin
				max_q <= day_value;
			end
		end
	end

	// search interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (cmd.init_search) begin
			low_q  <= min_q;
			high_q <= max_q;
		end else if (cmd.update_search) begin
			if (status.feasible) begin
				high_q <= thr_q;
			end else begin
				low_q <= thr_q + VALUE_BITS'(1);
			end
		end
	end

	// scan: read issue, then greedy run counting on the registered read in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			rd_addr_q <= '0;
			issuing_q <= 1'b0;
			vld_s1    <= 1'b0;
			len_q     <= '0;
			runs_q    <= '0;
		end else begin
			vld_s1 <= issuing_q;
			if (cmd.start_scan) begin
				thr_q     <= cmd.thr_max ? max_q : mid;
				rd_addr_q <= '0;
				issuing_q <= 1'b1;
				len_q     <= '0;
				runs_q    <= '0;
			end else begin
				if (issuing_q) begin
					rd_addr_q <= rd_addr_q + CNT_BITS'(1);
					if (rd_addr_q + CNT_BITS'(1) >= count_q) begin
						issuing_q <= 1'b0;
					end
				end
				if (vld_s1) begin
					if (len_next >= {1'b0, k_eff}) begin
						len_q  <= '0;
						runs_q <= runs_q + CNT_BITS'(1);
					end else begin
						len_q <= len_next[CFG_BITS-1:0];
					end
				end
			end
		end
	end

endmodule

// File: sv/mtkr_ctrl.sv
// ----------------------------------------------------------------------------
// mtkr_ctrl
// Controller: loading, feasibility check at the maximum, binary search
// sequencing and the result handshake.
// ----------------------------------------------------------------------------
module mtkr_ctrl import mtkr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_SCAN_MAX,
		S_STEP,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   ok_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == S_LOAD);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.result_ok = ok_q;
		case (state_q)
			S_LOAD: begin
				cmd.load         = accept;
				cmd.capture_prod = accept && is_last;
			end
			S_CHECK: begin
				cmd.start_scan = status.count_ok;
				cmd.thr_max    = 1'b1;
			end
			S_SCAN_MAX: begin
				cmd.init_search = status.scan_done && status.feasible;
			end
			S_STEP: begin
				cmd.start_scan = status.low_lt_high;
			end
			S_SCAN: begin
				cmd.update_search = status.scan_done;
			end
			S_FINISH: begin
				cmd.finish = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
		end else begin
			// a new result may replace the one taken at this edge
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept && is_last) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (status.count_ok) begin
						state_q <= S_SCAN_MAX;
					end else begin
						ok_q    <= 1'b0;
						state_q <= S_FINISH;
					end
				end
				S_SCAN_MAX: begin
					if (status.scan_done) begin
						if (status.feasible) begin
							state_q <= S_STEP;
						end else begin
							ok_q    <= 1'b0;
							state_q <= S_FINISH;
						end
					end
				end
				S_STEP: begin
					if (status.low_lt_high) begin
						state_q <= S_SCAN;
					end else begin
						ok_q    <= 1'b1;
						state_q <= S_FINISH;
					end
				end
				S_SCAN: begin
					if (status.scan_done) begin
						state_q <= S_STEP;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams arrays of day values into min_threshold_for_k_runs_search under
// several run count / run length settings and checks each threshold result
// against a binary search over a greedy run count done in the bench.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mtkr_pkg::*;

	typedef struct packed {
		value_t day;
		logic   ok;
	} threshold_t;

	localparam value_t DAY_TOP = '1;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	value_t              day_value;
	logic                is_last;
	logic                out_valid;
	logic                out_ready;
	value_t              min_day;
	logic                possible;
	logic                cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	cfg_t                cfg_data;

	threshold_t pending_thresholds[$];
	value_t     day_store[MAX_ITEMS];
	int         stored_days = 0;
	value_t     day_floor = '1;
	value_t     day_ceiling = '0;
	cfg_t       bouquet_count_reg = 1;
	cfg_t       bouquet_size_reg = 1;

	int failures = 0;
	int days_sent = 0;
	int arrays_sent = 0;
	int results_seen = 0;
	int feasible_seen = 0;
	int reg_writes = 0;
	int burst_left = 0;

	min_threshold_for_k_runs_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.day_value (day_value),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.min_day   (min_day),
		.possible  (possible),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("min_threshold_for_k_runs_search: mismatch");
		$finish;
	end

	function automatic void note_failure(string msg);
		failures++;
		if (failures <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// greedy scan: a value above the threshold breaks the run, a full run restarts it
	function automatic bit runs_reach(value_t thr, int m, int k);
		int run_len;
		int found;
		run_len = 0;
		found = 0;
		for (int i = 0; i < stored_days; i++) begin
			if (day_store[i] <= thr) begin
				run_len++;
			end else begin
				run_len = 0;
			end
			if (run_len >= k) begin
				run_len = 0;
				found++;
			end
		end
		return found >= m;
	endfunction

	function automatic threshold_t find_min_day();
		threshold_t res;
		int         m;
		int         k;
		value_t     lo;
		value_t     hi;
		value_t     mid;
		m = (bouquet_count_reg == 0) ? 1 : int'(bouquet_count_reg);
		k = (bouquet_size_reg == 0) ? 1 : int'(bouquet_size_reg);
		res.day = '0;
		res.ok = 1'b0;
		if (longint'(stored_days) >= longint'(m) * longint'(k) && runs_reach(day_ceiling, m, k)) begin
			lo = day_floor;
			hi = day_ceiling;
			while (lo < hi) begin
				mid = lo + ((hi - lo) >> 1);
				if (runs_reach(mid, m, k)) begin
					hi = mid;
				end else begin
					lo = mid + 1'b1;
				end
			end
			res.day = hi;
			res.ok = 1'b1;
		end
		return res;
	endfunction

	function automatic void record_day(value_t v, bit last);
		// past the store depth a request is dropped, but its last flag still closes the array
		if (stored_days < MAX_ITEMS) begin
			day_store[stored_days] = v;
			stored_days++;
			if (v < day_floor) day_floor = v;
			if (v > day_ceiling) day_ceiling = v;
		end
		days_sent++;
		if (last) begin
			pending_thresholds.push_back(find_min_day());
			arrays_sent++;
			stored_days = 0;
			day_floor = '1;
			day_ceiling = '0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if (r < 5) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic value_t pick_day(int style);
		case (style)
			0: return value_t'($urandom_range(0, 15));
			1: return value_t'($urandom);
			2: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return DAY_TOP;
					default: return value_t'($urandom);
				endcase
			end
			default: return DAY_TOP - value_t'($urandom_range(0, 7));
		endcase
	endfunction

	// valid stays up across back-to-back requests; it only drops ahead of a gap
	task automatic send_day(value_t v, bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		day_value <= v;
		is_last <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		record_day(v, last);
	endtask

	task automatic send_array(value_t days[$]);
		foreach (days[i]) begin
			send_day(days[i], i == days.size() - 1);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_thresholds.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_registers(int m, int k);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_BOUQUET_COUNT;
		cfg_data <= cfg_t'(m);
		@(posedge clk);
		cfg_index <= REG_BOUQUET_SIZE;
		cfg_data <= cfg_t'(k);
		@(posedge clk);
		cfg_we <= 1'b0;
		bouquet_count_reg = cfg_t'(m);
		bouquet_size_reg = cfg_t'(k);
		reg_writes += 2;
	endtask

	task automatic test_directed();
		value_t days[$];
		// reset values of both registers
		days = '{0};
		send_array(days);
		days = '{DAY_TOP};
		send_array(days);
		// zero in a register counts as one
		write_registers(0, 0);
		days = '{5, 3, 9};
		send_array(days);
		write_registers(2, 2);
		days = '{1, 10, 2, 3, 7, 4};
		send_array(days);
		// fewer values than m*k
		write_registers(3, 2);
		days = '{4, 4, 4, 4, 4};
		send_array(days);
		// largest register values, product far past the store depth
		write_registers(2047, 2047);
		days = '{7, 1};
		send_array(days);
		write_registers(1, 3);
		days = '{DAY_TOP, 0, DAY_TOP, DAY_TOP};
		send_array(days);
	endtask

	task automatic test_store_full();
		value_t days[$];
		write_registers(2, 512);
		for (int i = 0; i < MAX_ITEMS; i++) begin
			days.push_back(pick_day($urandom_range(1, 3)));
		end
		// overflow values are zero, no larger than anything stored, so taking one in would show
		repeat (6) days.push_back('0);
		send_array(days);
	endtask

	task automatic test_random_arrays();
		int     phase_m[12] = '{0, 1, 2, 3, 2047, 1, 2047, 4, 1, 8, 32, 1024};
		int     phase_k[12] = '{0, 1, 3, 2, 2047, 2047, 1, 4, 8, 1, 8, 1};
		int     m;
		int     k;
		int     need;
		int     len;
		int     style;
		int     budget;
		int     r;
		value_t days[$];
		for (int p = 0; p < 16; p++) begin
			if (p < 12) begin
				m = phase_m[p];
				k = phase_k[p];
			end else begin
				m = $urandom_range(1, 6);
				k = $urandom_range(1, 6);
			end
			write_registers(m, k);
			need = (m == 0 ? 1 : m) * (k == 0 ? 1 : k);
			budget = days_sent + 6;
			while (days_sent < budget) begin
				r = $urandom_range(0, 99);
				// sizes near m*k keep the search on the edge of feasibility
				if (r < 3) begin
					len = $urandom_range(100, 400);
				end else if (need <= 40 || (need <= 300 && r < 8)) begin
					len = need + $urandom_range(0, 10) - 3;
					if (len < 1) len = 1;
				end else begin
					len = $urandom_range(1, 24);
				end
				style = $urandom_range(0, 4);
				days.delete();
				repeat (len) begin
					days.push_back(pick_day(style == 4 ? $urandom_range(0, 3) : style));
				end
				send_array(days);
			end
		end
	endtask

	initial begin
		int   hold;
		logic level;
		out_ready <= 1'b0;
		hold = 0;
		level = 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						level = 1'b1;
						hold = $urandom_range(1, 6);
					end
					4: begin
						level = 1'b1;
						hold = $urandom_range(30, 120);
					end
					5, 6, 7: begin
						level = 1'b0;
						hold = $urandom_range(1, 3);
					end
					default: begin
						level = 1'b0;
						hold = $urandom_range(10, 40);
					end
				endcase
			end
			hold--;
			out_ready <= level;
		end
	end

	always @(posedge clk) begin
		threshold_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_thresholds.size() == 0) begin
				note_failure($sformatf("unexpected result: min_day=%0d possible=%0b",
					min_day, possible));
			end else begin
				want = pending_thresholds.pop_front();
				if (want.ok) feasible_seen++;
				if (min_day !== want.day || possible !== want.ok) begin
					note_failure($sformatf(
						"result %0d: expected min_day=%0d possible=%0b, got min_day=%0d possible=%0b",
						results_seen, want.day, want.ok, min_day, possible));
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		day_value <= '0;
		is_last <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BOUQUET_COUNT;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_store_full();
		test_random_arrays();
		wait_drained();
		repeat (100) @(posedge clk);
		$display("loaded %0d days in %0d arrays, checked %0d thresholds (%0d feasible)",
			days_sent, arrays_sent, results_seen, feasible_seen);
		$display("%0d register writes, %0d failures", reg_writes, failures);
		if (failures == 0) begin
			$display("min_threshold_for_k_runs_search: match");
		end else begin
			$display("min_threshold_for_k_runs_search: mismatch");
		end
		$finish;
	end

endmodule

// File: min_threshold_for_k_runs_search.f
sv/mtkr_pkg.sv
sv/mtkr_dp.sv
sv/mtkr_ctrl.sv
sv/min_threshold_for_k_runs_search.sv
bench/tb_top.sv
